// File: hdl/swpd_pkg.sv
// ----------------------------------------------------------------------------
// swpd_pkg
// Shared types and constants for the sync word packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package swpd_pkg;

  // Width of the sync search window
  localparam int unsigned SYNC_BITS = 24;

  localparam int unsigned SYNC_WORD_W = 24;
  localparam int unsigned LEN_W       = 8;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned BIT_CNT_W   = 4;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [SYNC_WORD_W-1:0] SYNC_WORD_RST = 24'h70EED2;
  localparam logic [LEN_W-1:0]       EXP_LEN_RST   = 8'h07;
  localparam logic [LEN_W-1:0]       MIN_LEN       = 8'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_LEN   = 1'b1;

  typedef enum logic [1:0] {
    MODE_SEARCH  = 2'd0,
    MODE_HEADER  = 2'd1,
    MODE_PAYLOAD = 2'd2
  } mode_t;

  typedef struct packed {
    logic [SYNC_WORD_W-1:0] sync_word;
    logic [LEN_W-1:0]       expected_length;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              last_byte;
  } result_t;

  // Core status toward the top level
  typedef struct packed {
    logic result_valid;   // accepted bit completes a payload byte
    logic emit_pending;   // next accepted bit would complete a payload byte
  } core_status_t;

endpackage

`default_nettype wire

// File: hdl/swpd_core.sv
// ----------------------------------------------------------------------------
// swpd_core
// Sync search, header check and payload byte assembly, one bit per cycle while bit_fire is high.
// ----------------------------------------------------------------------------
`default_nettype none

module swpd_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  bit_fire,
  input  wire logic                  line_bit,
  input  wire swpd_pkg::cfg_t        cfg,
  output swpd_pkg::core_status_t     status,
  output swpd_pkg::result_t          result
);

  swpd_pkg::mode_t                         mode, mode_next;
  logic [swpd_pkg::SYNC_BITS-1:0]          bit_window, bit_window_next;
  logic [swpd_pkg::BIT_CNT_W-1:0]          bit_count, bit_count_next;
  logic [swpd_pkg::LEN_W-1:0]              byte_count, byte_count_next;

  logic [swpd_pkg::SYNC_BITS-1:0]          win_shift;
  logic [swpd_pkg::SYNC_BITS-1:0]          sync_ref;
  logic [swpd_pkg::BYTE_W-1:0]             byte_shift;
  logic [swpd_pkg::BIT_CNT_W-1:0]          bit_inc;
  logic [swpd_pkg::LEN_W-1:0]              byte_inc;
  logic                                    sync_hit;
  logic                                    byte_done;
  logic                                    hdr_ok;
  logic                                    is_last;

  assign win_shift  = {bit_window[swpd_pkg::SYNC_BITS-2:0], line_bit};
  assign sync_ref   = swpd_pkg::SYNC_BITS'(cfg.sync_word);
  assign byte_shift = {bit_window[swpd_pkg::BYTE_W-2:0], line_bit};
  assign bit_inc    = bit_count + 1'b1;
  assign byte_inc   = byte_count + 1'b1;
  assign sync_hit   = (win_shift == sync_ref);
  // count reaches 8 (wraps at 16, so bit 3 marks >= 8)
  assign byte_done  = bit_inc[swpd_pkg::BIT_CNT_W-1];
  assign hdr_ok     = (byte_shift == cfg.expected_length) &&
                      (cfg.expected_length >= swpd_pkg::MIN_LEN);
  // 9-bit compare so a count of 255 does not wrap
  assign is_last    = ({1'b0, byte_inc} + 9'd1) >= {1'b0, cfg.expected_length};

  // Next mode
  always_comb begin
    mode_next = mode;
    if (bit_fire) begin
      case (mode)
        swpd_pkg::MODE_SEARCH: begin
          if (sync_hit) mode_next = swpd_pkg::MODE_HEADER;
        end
        swpd_pkg::MODE_HEADER: begin
          if (byte_done) begin
            mode_next = hdr_ok ? swpd_pkg::MODE_PAYLOAD : swpd_pkg::MODE_SEARCH;
          end
        end
        swpd_pkg::MODE_PAYLOAD: begin
          if (byte_done && is_last) mode_next = swpd_pkg::MODE_SEARCH;
        end
        default: begin
          mode_next = swpd_pkg::MODE_SEARCH;
        end
      endcase
    end
  end

  // Window and counters; window is cleared on every mode entry
  always_comb begin
    bit_window_next = bit_window;
    bit_count_next  = bit_count;
    byte_count_next = byte_count;
    if (bit_fire) begin
      case (mode)
        swpd_pkg::MODE_SEARCH: begin
          if (sync_hit) begin
            bit_window_next = '0;
            bit_count_next  = '0;
          end else begin
            bit_window_next = win_shift;
          end
        end
        swpd_pkg::MODE_HEADER: begin
          bit_count_next = bit_inc;
          if (byte_done) begin
            bit_window_next = '0;
            if (hdr_ok) begin
              bit_count_next  = '0;
              byte_count_next = '0;
            end
          end else begin
            bit_window_next = swpd_pkg::SYNC_BITS'(byte_shift);
          end
        end
        swpd_pkg::MODE_PAYLOAD: begin
          if (byte_done) begin
            bit_window_next = '0;
            bit_count_next  = '0;
            byte_count_next = byte_inc;
          end else begin
            bit_window_next = swpd_pkg::SYNC_BITS'(byte_shift);
            bit_count_next  = bit_inc;
          end
        end
        default: begin
          bit_window_next = '0;
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    status.emit_pending = (mode == swpd_pkg::MODE_PAYLOAD) && byte_done;
    status.result_valid = bit_fire && status.emit_pending;
    result.payload_byte = byte_shift;
    result.last_byte    = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= swpd_pkg::MODE_SEARCH;
      bit_window <= '0;
      bit_count  <= '0;
      byte_count <= '0;
    end else begin
      mode       <= mode_next;
      bit_window <= bit_window_next;
      bit_count  <= bit_count_next;
      byte_count <= byte_count_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/swpd_out_reg.sv
// ----------------------------------------------------------------------------
// swpd_out_reg
// Result register holding one payload byte until the downstream takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module swpd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire swpd_pkg::result_t load_data,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output swpd_pkg::result_t      out_data,
  output logic                   full_stalled
);

  logic              valid, valid_next;
  swpd_pkg::result_t data;

  assign valid_next   = load || (valid && !out_ready);
  assign out_valid    = valid;
  assign out_data     = data;
  assign full_stalled = valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

`default_nettype wire

// File: hdl/sync_word_packet_deframer_unit.sv
// ----------------------------------------------------------------------------
// sync_word_packet_deframer_unit
// Bit-serial deframer: finds a 24-bit sync word, checks a length header and
// hands out the payload bytes that follow, flagging the last one.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   -------------------------------
//  input     in_valid/in_ready    line_bit (1 b)
//  output    out_valid/out_ready  payload_byte (8 b), last_byte (1 b)
//  config    cfg_we               cfg_index (1 b), cfg_data (24 b)
//
// One bit per cycle while in_ready is high; the mode/window/counter update
// is registered, and a finished byte shows on the output in the cycle after
// the bit that completes it. Synchronous reset returns to sync search with the
// window and counters cleared and registers at their defaults. A stalled
// output request blocks only a bit that would complete a payload byte;
// every other bit is still taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_word_packet_deframer_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // bit input
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                line_bit,
  // byte output
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [swpd_pkg::BYTE_W-1:0]              payload_byte,
  output logic                                     last_byte,
  // configuration writes
  input  wire logic                                cfg_we,
  input  wire logic [swpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [swpd_pkg::SYNC_WORD_W-1:0]    cfg_data
);

  swpd_pkg::cfg_t         cfg;
  swpd_pkg::core_status_t status;
  swpd_pkg::result_t      core_result;
  swpd_pkg::result_t      out_data;
  logic                   bit_fire;
  logic                   full_stalled;

  // Config registers; the user must write them only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_word       <= swpd_pkg::SYNC_WORD_RST;
      cfg.expected_length <= swpd_pkg::EXP_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        swpd_pkg::REG_SYNC_WORD: cfg.sync_word       <= cfg_data;
        swpd_pkg::REG_EXP_LEN:   cfg.expected_length <= cfg_data[swpd_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold off only the bit that would produce a byte into a stalled slot
  assign in_ready = !(status.emit_pending && full_stalled);
  assign bit_fire = in_valid && in_ready;

  swpd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .bit_fire (bit_fire),
    .line_bit (line_bit),
    .cfg      (cfg),
    .status   (status),
    .result   (core_result)
  );

  swpd_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (status.result_valid),
    .load_data    (core_result),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .full_stalled (full_stalled)
  );

  assign payload_byte = out_data.payload_byte;
  assign last_byte    = out_data.last_byte;

endmodule

`default_nettype wire

// File: hdl/swpd_checker.sv
// ----------------------------------------------------------------------------
// swpd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swpd_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [swpd_pkg::BYTE_W-1:0]      payload_byte,
  input wire logic                             last_byte
);

  // no result right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output request present after reset");

  // a new result needs an accepted bit the cycle before
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) ##1 out_valid |-> $past(in_valid && in_ready))
    else $error("result without an accepted bit");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(payload_byte) && $stable(last_byte))
    else $error("output payload changed while stalled");

endmodule

bind sync_word_packet_deframer_unit swpd_checker u_swpd_checker (.*);

`default_nettype wire
